### hdl/gnms_pkg.sv
// gnms_pkg: shared types and constants of the greedy iou nms block
// used by the interfaces, the box store, the iou unit and the top level
`default_nettype none

package gnms_pkg;

  localparam int unsigned GNMS_MAX_KEPT = 64;

  localparam int unsigned COORD_W = 14;
  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned AREA_W  = 2 * SIZE_W;
  localparam int unsigned UNION_W = AREA_W + 1;
  localparam int unsigned THR_W   = 17;
  localparam int unsigned IDX_W   = 16;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(32768);
  localparam logic [IDX_W-1:0] IDX_MAX   = {IDX_W{1'b1}};

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
  } box_t;

  // status from the iou unit back to the sequencer
  typedef struct packed {
    logic done;
    logic hit;
  } iou_stat_t;

endpackage

`default_nettype wire

### hdl/gnms_if.sv
// gnms_if: valid/ready channel interfaces of the greedy iou nms block
// box input, result output and threshold write channel; uses gnms_pkg
`default_nettype none

interface gnms_box_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 frame_start;
  logic signed [gnms_pkg::COORD_W-1:0]  box_x;
  logic signed [gnms_pkg::COORD_W-1:0]  box_y;
  logic [gnms_pkg::SIZE_W-1:0]          box_w;
  logic [gnms_pkg::SIZE_W-1:0]          box_h;

  modport source (output valid, frame_start, box_x, box_y, box_w, box_h, input ready);
  modport sink (input valid, frame_start, box_x, box_y, box_w, box_h, output ready);
endinterface

interface gnms_res_if;
  logic                         valid;
  logic                         ready;
  logic                         keep;
  logic [gnms_pkg::IDX_W-1:0]   box_index;
  logic                         overflow;

  modport source (output valid, keep, box_index, overflow, input ready);
  modport sink (input valid, keep, box_index, overflow, output ready);
endinterface

interface gnms_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [gnms_pkg::THR_W-1:0]   iou_threshold;

  modport source (output valid, iou_threshold, input ready);
  modport sink (input valid, iou_threshold, output ready);
endinterface

`default_nettype wire

### hdl/greedy_iou_nms_top.sv
// greedy_iou_nms_top: greedy non-maximum suppression by iou over a frame
// sequencer with the kept-box store (gnms_store) and iou unit (gnms_iou); uses gnms_pkg
//
// usage:
//   box_i carries score-ordered boxes, one transaction per box; frame_start on a
//   box empties the kept list and restarts the index at zero before that box.
//   res_o returns one transaction per box: keep, box_index and overflow.
//   cfg_i writes iou_threshold (Q1.16) at any time the block is idle; always ready.
// processing:
//   a box is tested against the n boxes kept so far in the frame (at most MaxKept);
//   each kept box costs one store read and a three-stage iou test, and the scan
//   stops at the first kept box that suppresses. one box is processed at a time;
//   the next box is taken as soon as the result of the current one moves into the
//   output register.
// stalls and reset:
//   a result held by a stalled receiver stays in the output register while the
//   next box is processed; that box then waits for the register to empty.
//   reset empties the kept list, clears the index and sets the threshold to one half.
//   the store itself needs no clearing, only entries below the kept count are read.
`default_nettype none

module greedy_iou_nms_top #(
  parameter int unsigned MaxKept = gnms_pkg::GNMS_MAX_KEPT
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gnms_cfg_if.sink   cfg_i,
  gnms_box_if.sink   box_i,
  gnms_res_if.source res_o
);
  import gnms_pkg::*;

  localparam int unsigned AddrW = (MaxKept > 1) ? $clog2(MaxKept) : 1;
  localparam int unsigned CntW  = $clog2(MaxKept + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(MaxKept);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_START,
    ST_WAIT,
    ST_DONE
  } state_e;

  state_e            state_q;
  box_t              cur_q;
  logic [AREA_W-1:0] area_a_q;
  logic [CntW-1:0]   count_q, k_q, eff_cnt;
  logic [IDX_W-1:0]  pos_q, idx_q, pos_base;
  logic              keep_q;
  logic [THR_W-1:0]  thr_q;
  logic              out_valid_q, out_keep_q, out_ovf_q;
  logic [IDX_W-1:0]  out_idx_q;

  logic      box_acc, slot_free, full, mem_we, mem_re;
  box_t      rdata;
  iou_stat_t iou_stat;

  assign cfg_i.ready = 1'b1;
  assign box_i.ready = (state_q == ST_IDLE);
  assign box_acc     = box_i.valid && box_i.ready;
  assign slot_free   = !out_valid_q || res_o.ready;
  assign full        = (count_q == CntFull);
  assign eff_cnt     = box_i.frame_start ? '0 : count_q;
  assign pos_base    = box_i.frame_start ? '0 : pos_q;
  assign mem_re      = (state_q == ST_READ);
  assign mem_we      = (state_q == ST_DONE) && slot_free && keep_q && !full;

  assign res_o.valid     = out_valid_q;
  assign res_o.keep      = out_keep_q;
  assign res_o.box_index = out_idx_q;
  assign res_o.overflow  = out_ovf_q;

  gnms_store #(
    .Depth (MaxKept),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (cur_q),
    .re_i    (mem_re),
    .raddr_i (k_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  gnms_iou u_iou (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == ST_START),
    .a_i      (cur_q),
    .area_a_i (area_a_q),
    .b_i      (rdata),
    .thr_i    (thr_q),
    .stat_o   (iou_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      k_q         <= '0;
      keep_q      <= 1'b0;
      idx_q       <= '0;
      thr_q       <= THR_RESET;
      out_valid_q <= 1'b0;
      out_keep_q  <= 1'b0;
      out_idx_q   <= '0;
      out_ovf_q   <= 1'b0;
      cur_q       <= '0;
      area_a_q    <= '0;
    end else begin
      if (cfg_i.valid) begin
        thr_q <= cfg_i.iou_threshold;
      end
      if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (box_acc) begin
            cur_q.x  <= box_i.box_x;
            cur_q.y  <= box_i.box_y;
            cur_q.w  <= box_i.box_w;
            cur_q.h  <= box_i.box_h;
            area_a_q <= {{SIZE_W{1'b0}}, box_i.box_w} * {{SIZE_W{1'b0}}, box_i.box_h};
            count_q  <= eff_cnt;
            idx_q    <= pos_base;
            pos_q    <= (pos_base == IDX_MAX) ? pos_base : pos_base + IDX_W'(1);
            k_q      <= '0;
            keep_q   <= 1'b1;
            state_q  <= (eff_cnt == '0) ? ST_DONE : ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_START;
        end
        ST_START: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (iou_stat.done) begin
            if (iou_stat.hit) begin
              keep_q  <= 1'b0;
              state_q <= ST_DONE;
            end else if (k_q + CntW'(1) == count_q) begin
              state_q <= ST_DONE;
            end else begin
              k_q     <= k_q + CntW'(1);
              state_q <= ST_READ;
            end
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_keep_q  <= keep_q;
            out_idx_q   <= idx_q;
            out_ovf_q   <= keep_q && full;
            if (keep_q && !full) begin
              count_q <= count_q + CntW'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/gnms_store.sv
// gnms_store: synchronous memory of kept boxes, one write and one read port
// read data registered; uses gnms_pkg
`default_nettype none

module gnms_store #(
  parameter int unsigned Depth = gnms_pkg::GNMS_MAX_KEPT,
  parameter int unsigned AddrW = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire gnms_pkg::box_t   wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output gnms_pkg::box_t        rdata_o
);
  import gnms_pkg::*;

  box_t mem [Depth];
  box_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/gnms_iou.sv
// gnms_iou: three-stage iou test of the current box against one kept box
// overlap extents, then intersection and area, then union, then threshold compare
`default_nettype none

module gnms_iou (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire gnms_pkg::box_t              a_i,
  input  wire logic [gnms_pkg::AREA_W-1:0] area_a_i,
  input  wire gnms_pkg::box_t              b_i,
  input  wire logic [gnms_pkg::THR_W-1:0]  thr_i,
  output gnms_pkg::iou_stat_t              stat_o
);
  import gnms_pkg::*;

  localparam int unsigned ProdW = THR_W + UNION_W;

  logic signed [COORD_W:0]   a_end, b_end, x_hi, y_hi, ay_end, by_end;
  logic signed [COORD_W-1:0] x_lo, y_lo;
  logic signed [COORD_W+1:0] dx_d, dy_d;

  logic signed [COORD_W+1:0] dx_q, dy_q;
  logic [SIZE_W-1:0]         bw_q, bh_q;
  logic [AREA_W-1:0]         inter_q, area_b_q;
  logic [UNION_W-1:0]        uni_q;
  logic [2:0]                v_q;

  logic [ProdW-1:0] lhs, rhs;

  always_comb begin
    a_end  = {a_i.x[COORD_W-1], a_i.x} + $signed({2'b00, a_i.w});
    b_end  = {b_i.x[COORD_W-1], b_i.x} + $signed({2'b00, b_i.w});
    ay_end = {a_i.y[COORD_W-1], a_i.y} + $signed({2'b00, a_i.h});
    by_end = {b_i.y[COORD_W-1], b_i.y} + $signed({2'b00, b_i.h});
    x_lo   = (a_i.x > b_i.x) ? a_i.x : b_i.x;
    y_lo   = (a_i.y > b_i.y) ? a_i.y : b_i.y;
    x_hi   = (a_end < b_end) ? a_end : b_end;
    y_hi   = (ay_end < by_end) ? ay_end : by_end;
    dx_d   = {x_hi[COORD_W], x_hi} - {{2{x_lo[COORD_W-1]}}, x_lo};
    dy_d   = {y_hi[COORD_W], y_hi} - {{2{y_lo[COORD_W-1]}}, y_lo};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      bw_q <= b_i.w;
      bh_q <= b_i.h;
    end
    // a positive extent never exceeds the smaller box size, so 13 bits carry it
    if (dx_q > 0 && dy_q > 0) begin
      inter_q <= {{SIZE_W{1'b0}}, dx_q[SIZE_W-1:0]} * {{SIZE_W{1'b0}}, dy_q[SIZE_W-1:0]};
    end else begin
      inter_q <= '0;
    end
    area_b_q <= {{SIZE_W{1'b0}}, bw_q} * {{SIZE_W{1'b0}}, bh_q};
    uni_q    <= {1'b0, area_a_i} + {1'b0, area_b_q} - {1'b0, inter_q};
  end

  always_comb begin
    lhs = {{(ProdW - AREA_W - 16){1'b0}}, inter_q, 16'b0};
    rhs = {{UNION_W{1'b0}}, thr_i} * {{THR_W{1'b0}}, uni_q};
    stat_o.done = v_q[2];
    // empty union counts as zero iou
    if (uni_q == '0) begin
      stat_o.hit = (thr_i == '0);
    end else begin
      stat_o.hit = (lhs >= rhs);
    end
  end

endmodule

`default_nettype wire

### dv/tb_greedy_iou_nms_top.sv
// tb_greedy_iou_nms_top: self-checking bench for greedy_iou_nms_top, predicting keep,
// box_index and overflow per box and comparing every result transaction in order
// depends on gnms_pkg, the gnms_if channel interfaces and the block rtl
`timescale 1ns / 100ps

module tb_greedy_iou_nms_top;
  import gnms_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 400;

  typedef enum logic [1:0] {OP_BOX, OP_CFG, OP_MODE} stim_kind_e;

  typedef struct {
    stim_kind_e       kind;
    logic             fs;
    box_t             bx;
    logic [THR_W-1:0] thr;
    int               src_pct;
    int               snk_pct;
  } stim_op_t;

  typedef struct packed {
    logic             keep;
    logic [IDX_W-1:0] box_index;
    logic             overflow;
  } nms_verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  gnms_cfg_if cfg_if ();
  gnms_box_if box_if ();
  gnms_res_if res_if ();

  greedy_iou_nms_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .box_i (box_if),
    .res_o (res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  box_t             kept_box[GNMS_MAX_KEPT];
  int               kept_n = 0;
  int               frame_pos = 0;
  logic [THR_W-1:0] thr_now = THR_RESET;

  stim_op_t     stim_q[$];
  nms_verdict_t verdict_q[$];
  int           in_flight = 0;
  int           err_cnt = 0;
  int           res_seen = 0;
  int           quiet_cycles = 0;
  int           src_idle_pct = 0;
  int           snk_stall_pct = 0;

  task automatic report_mismatch(string what, longint got, longint want);
    if (err_cnt < 40) begin
      $display("mismatch in result %0d: %s got %0d expected %0d", res_seen, what, got, want);
    end
    err_cnt++;
  endtask

  // exact fixed point iou compare: inter * 65536 >= thr * union
  function automatic bit iou_reaches(box_t a, box_t b, logic [THR_W-1:0] thr);
    longint ax, ay, bx, by, aw, ah, bw, bh, x0, y0, x1, y1, inter, uni;
    ax = $signed(a.x);
    ay = $signed(a.y);
    bx = $signed(b.x);
    by = $signed(b.y);
    aw = a.w;
    ah = a.h;
    bw = b.w;
    bh = b.h;
    x0 = (ax > bx) ? ax : bx;
    y0 = (ay > by) ? ay : by;
    x1 = (ax + aw < bx + bw) ? ax + aw : bx + bw;
    y1 = (ay + ah < by + bh) ? ay + ah : by + bh;
    inter = (x1 > x0 && y1 > y0) ? (x1 - x0) * (y1 - y0) : 0;
    uni = aw * ah + bw * bh - inter;
    // zero union counts as zero iou
    if (uni <= 0) return thr == 0;
    return inter * 65536 >= longint'(thr) * uni;
  endfunction

  function automatic nms_verdict_t judge_box(logic fs, box_t cur);
    nms_verdict_t v;
    v.keep = 1'b1;
    v.overflow = 1'b0;
    if (fs) begin
      kept_n = 0;
      frame_pos = 0;
    end
    v.box_index = IDX_W'(frame_pos);
    if (frame_pos < 65535) frame_pos++;
    for (int k = 0; k < kept_n; k++) begin
      if (iou_reaches(cur, kept_box[k], thr_now)) begin
        v.keep = 1'b0;
        break;
      end
    end
    if (v.keep) begin
      if (kept_n < GNMS_MAX_KEPT) begin
        kept_box[kept_n] = cur;
        kept_n++;
      end else begin
        v.overflow = 1'b1;
      end
    end
    return v;
  endfunction

  task automatic push_box(logic fs, int x, int y, int w, int h);
    stim_op_t op;
    op.kind = OP_BOX;
    op.fs = fs;
    op.bx.x = COORD_W'(x);
    op.bx.y = COORD_W'(y);
    op.bx.w = SIZE_W'(w);
    op.bx.h = SIZE_W'(h);
    stim_q.push_back(op);
  endtask

  task automatic push_cfg(int thr);
    stim_op_t op;
    op.kind = OP_CFG;
    op.thr = THR_W'(thr);
    stim_q.push_back(op);
  endtask

  task automatic push_mode(int src, int snk);
    stim_op_t op;
    op.kind = OP_MODE;
    op.src_pct = src;
    op.snk_pct = snk;
    stim_q.push_back(op);
  endtask

  task automatic push_noise_box(logic fs);
    push_box(fs, $signed(COORD_W'($urandom())), $signed(COORD_W'($urandom())),
             $urandom_range(8191), $urandom_range(8191));
  endtask

  // mostly clustered boxes around one spot so suppression really happens
  task automatic push_frame(int len);
    int cx, cy, r;
    logic fs;
    cx = int'($urandom_range(15800)) - 7900;
    cy = int'($urandom_range(15800)) - 7900;
    for (int i = 0; i < len; i++) begin
      fs = (i == 0) || ($urandom_range(99) < 3);
      r = $urandom_range(99);
      if (r < 80) begin
        push_box(fs, cx + int'($urandom_range(80)) - 40, cy + int'($urandom_range(80)) - 40,
                 $urandom_range(1, 64), $urandom_range(1, 64));
      end else if (r < 90) begin
        push_noise_box(fs);
      end else begin
        push_box(fs, cx + int'($urandom_range(20)), cy + int'($urandom_range(20)),
                 ($urandom_range(1) ? 0 : $urandom_range(30)), ($urandom_range(1) ? 0 : 5));
      end
    end
  endtask

  // disjoint boxes so the store fills up and the last few overflow
  task automatic push_grid_frame();
    for (int i = 0; i < GNMS_MAX_KEPT + 4; i++) begin
      push_box(i == 0, -8000 + (i % 16) * 500, -8000 + (i / 16) * 500,
               $urandom_range(1, 400), $urandom_range(1, 400));
    end
  endtask

  task automatic push_phase(int src, int snk, int thr, int n, bit grid);
    int cnt, len;
    cnt = 0;
    push_mode(src, snk);
    push_cfg(thr);
    if (grid) push_grid_frame();
    while (cnt < n) begin
      len = $urandom_range(1, 12);
      push_frame(len);
      cnt += len;
    end
  endtask

  // box and threshold driver
  always @(posedge clk_i) begin : drive_stim
    stim_op_t op;
    logic     box_vld;
    logic     cfg_vld;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) in_flight--;
      if (box_if.valid && box_if.ready) begin
        op.bx.x = box_if.box_x;
        op.bx.y = box_if.box_y;
        op.bx.w = box_if.box_w;
        op.bx.h = box_if.box_h;
        verdict_q.push_back(judge_box(box_if.frame_start, op.bx));
        in_flight++;
      end
      if (cfg_if.valid && cfg_if.ready) thr_now = cfg_if.iou_threshold;
      if (!(box_if.valid && !box_if.ready) && !(cfg_if.valid && !cfg_if.ready)) begin
        box_vld = 1'b0;
        cfg_vld = 1'b0;
        if (stim_q.size() > 0) begin
          op = stim_q[0];
          case (op.kind)
            OP_MODE: begin
              src_idle_pct <= op.src_pct;
              snk_stall_pct <= op.snk_pct;
              void'(stim_q.pop_front());
            end
            OP_CFG: begin
              // threshold only changes once every result is back
              if (in_flight <= 0) begin
                cfg_vld = 1'b1;
                cfg_if.iou_threshold <= op.thr;
                void'(stim_q.pop_front());
              end
            end
            default: begin
              if ($urandom_range(99) >= src_idle_pct) begin
                box_vld = 1'b1;
                box_if.frame_start <= op.fs;
                box_if.box_x <= op.bx.x;
                box_if.box_y <= op.bx.y;
                box_if.box_w <= op.bx.w;
                box_if.box_h <= op.bx.h;
                void'(stim_q.pop_front());
              end
            end
          endcase
        end
        box_if.valid <= box_vld;
        cfg_if.valid <= cfg_vld;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin : check_results
    nms_verdict_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected result, box_index", res_if.box_index, -1);
      end else begin
        want = verdict_q.pop_front();
        if (res_if.keep !== want.keep) report_mismatch("keep", res_if.keep, want.keep);
        if (res_if.box_index !== want.box_index) begin
          report_mismatch("box_index", res_if.box_index, want.box_index);
        end
        if (res_if.overflow !== want.overflow) begin
          report_mismatch("overflow", res_if.overflow, want.overflow);
        end
      end
      res_seen++;
    end
    res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((box_if.valid && box_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : run_test
    box_if.valid = 1'b0;
    box_if.frame_start = 1'b0;
    box_if.box_x = '0;
    box_if.box_y = '0;
    box_if.box_w = '0;
    box_if.box_h = '0;
    cfg_if.valid = 1'b0;
    cfg_if.iou_threshold = '0;
    res_if.ready = 1'b0;

    // directed: reset threshold of one half first
    push_box(1, 0, 0, 10, 10);
    push_box(0, 0, 0, 10, 10);
    push_box(0, 5, 0, 10, 10);
    push_box(0, 3, 0, 10, 10);
    push_box(0, -8192, -8192, 8191, 8191);
    push_box(0, 8191, 8191, 8191, 8191);
    push_box(0, 100, 100, 0, 0);
    push_box(0, 100, 100, 0, 0);
    push_box(0, -1, -1, 8191, 0);
    push_box(0, 0, -8192, 0, 8191);
    // zero threshold: everything after the first kept box goes
    push_cfg(0);
    push_box(1, 8191, -8192, 1, 1);
    push_box(0, -8192, 8191, 5, 5);
    push_box(1, 0, 0, 0, 0);
    push_box(0, 0, 0, 0, 0);
    // threshold of exactly one: only identical boxes suppress
    push_cfg(65536);
    push_box(1, 10, 10, 20, 20);
    push_box(0, 10, 10, 20, 20);
    push_box(0, 11, 10, 20, 20);
    // threshold above one: nothing with a nonzero union suppresses
    push_cfg(131071);
    push_box(1, 10, 10, 20, 20);
    push_box(0, 10, 10, 20, 20);
    push_box(0, 0, 0, 8191, 8191);

    push_phase(0, 0, $urandom_range(1, 65536), 90, 1'b0);
    push_phase(79, 0, 65537, 90, 1'b1);
    push_phase(0, 79, $urandom_range(16384, 49152), 90, 1'b1);
    push_phase(15, 15, 1, 90, 1'b0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || box_if.valid || cfg_if.valid || in_flight > 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (verdict_q.size() != 0) report_mismatch("results missing, count", 0, verdict_q.size());

    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
